/* src/kmdr_pkg.sv */
package kmdr_pkg;

   // fixed field widths of the scan and report transactions
   localparam int KEYS_W     = 22;
   localparam int THRESH_W   = 16;
   localparam int SLOT_W     = 5;
   localparam int OUT_SLOTS  = 8;
   localparam int SLOT_IDX_W = 3;
   localparam int FILL_W     = 4;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef slot_type [OUT_SLOTS-1:0] slot_vec_type;

endpackage

/* src/key_matrix_debounce_reporter.sv */
// a scan in the input register moves to the result register once that register is empty or its report is taken
// throughput: one scan per cycle while the report side keeps taking transactions
// each scan passes an input register, then counter update and priority pick
// into the result register; a report stalled there holds one more scan in the
// input register and drops req_ready until the report is taken
// reset: all held counts cleared, hold threshold set to 50, both stages empty
module key_matrix_debounce_reporter
   import kmdr_pkg::*;
#(
   parameter int NUM_KEYS     = 22,
   parameter int REPORT_SLOTS = 8,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [THRESH_W-1:0] csr_hold_threshold,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEYS_W-1:0]   req_keys_closed,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_slot_zero,
   output logic [SLOT_W-1:0]   rsp_slot_one,
   output logic [SLOT_W-1:0]   rsp_slot_two,
   output logic [SLOT_W-1:0]   rsp_slot_three,
   output logic [SLOT_W-1:0]   rsp_slot_four,
   output logic [SLOT_W-1:0]   rsp_slot_five,
   output logic [SLOT_W-1:0]   rsp_slot_six,
   output logic [SLOT_W-1:0]   rsp_slot_seven
);

   localparam int CMP_W = ((COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W) + 1;

   logic [THRESH_W-1:0]    thresh_ff;
   logic                   in_valid_ff;
   logic [KEYS_W-1:0]      in_keys_ff;
   logic [COUNT_WIDTH-1:0] count_ff [NUM_KEYS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_KEYS];
   logic [COUNT_WIDTH-1:0] count_upd [NUM_KEYS];
   logic                   rsp_valid_ff;
   slot_vec_type           slots_ff;
   slot_vec_type           slots_in;
   logic [NUM_KEYS-1:0]    closed;
   logic [NUM_KEYS-1:0]    above;
   logic [NUM_KEYS-1:0]    take;
   logic [CMP_W-1:0]       thresh_ext;
   logic [COUNT_WIDTH-1:0] clamp_val;
   logic                   advance;

   // handshakes
   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_hold_threshold;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_keys_ff <= req_keys_closed;
      end
   end

   // keys past the scan width always read open
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_closed
      if (k < KEYS_W) begin : g_in
         assign closed[k] = in_keys_ff[k];
      end else begin : g_out
         assign closed[k] = 1'b0;
      end
   end

   assign thresh_ext = CMP_W'(thresh_ff);
   assign clamp_val  = COUNT_WIDTH'(thresh_ext + 1'b1);

   // saturating count when closed, clear when open, then compare
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (!closed[i]) begin
            count_upd[i] = '0;
         end else if (count_ff[i] == {COUNT_WIDTH{1'b1}}) begin
            count_upd[i] = count_ff[i];
         end else begin
            count_upd[i] = count_ff[i] + 1'b1;
         end
         above[i] = CMP_W'(count_upd[i]) > thresh_ext;
      end
   end

   kmdr_pick #(
      .NUM_KEYS     (NUM_KEYS),
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_pick (
      .above (above),
      .take  (take),
      .slots (slots_in)
   );

   // reported keys are clamped to one over the threshold
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         count_in[i] = take[i] ? clamp_val : count_upd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slots_ff <= slots_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_zero  = slots_ff[0];
   assign rsp_slot_one   = slots_ff[1];
   assign rsp_slot_two   = slots_ff[2];
   assign rsp_slot_three = slots_ff[3];
   assign rsp_slot_four  = slots_ff[4];
   assign rsp_slot_five  = slots_ff[5];
   assign rsp_slot_six   = slots_ff[6];
   assign rsp_slot_seven = slots_ff[7];

   // checks on pick order and stage flow
   a_empty_slots_trail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (slots_ff[0] == '0) |-> (slots_ff[1] == '0))
      else $error("report slot filled after an empty slot");

   a_slots_ascend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (NUM_KEYS < 32) && (slots_ff[1] != '0) |-> (slots_ff[1] > slots_ff[0]))
      else $error("reported keys not in ascending order");

   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result raised without a scan in the input register");

   a_stalled_keeps_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(slots_ff))
      else $error("stalled report changed");

endmodule

/* src/kmdr_pick.sv */
module kmdr_pick
   import kmdr_pkg::*;
#(
   parameter int NUM_KEYS     = 22,
   parameter int REPORT_SLOTS = 8
) (
   input  logic [NUM_KEYS-1:0] above,
   output logic [NUM_KEYS-1:0] take,
   output slot_vec_type        slots
);

   logic [FILL_W-1:0] filled;

   // fixed priority pick: first keys over threshold in ascending order
   always_comb begin
      filled = '0;
      take   = '0;
      slots  = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (above[i] && (filled < FILL_W'(REPORT_SLOTS))) begin
            take[i]                      = 1'b1;
            slots[filled[SLOT_IDX_W-1:0]] = SLOT_W'(i + 1);
            filled                       = filled + 1'b1;
         end
      end
   end

endmodule
